>>> sv/bbc_pkg.sv
// Shared constants, codes and types for the bracket balance checker.
package bbc_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_BRACE   = 2'd1;
	localparam logic [1:0] KIND_PAREN   = 2'd2;
	localparam logic [1:0] KIND_BRACKET = 2'd3;

	localparam logic [2:0] ST_RUN   = 3'd0;
	localparam logic [2:0] ST_UNBAL = 3'd4;
	localparam logic [2:0] ST_BAL   = 3'd5;
	localparam logic [2:0] ST_OVF   = 3'd6;

	localparam logic [7:0] CH_LBRACE   = 8'd123;
	localparam logic [7:0] CH_RBRACE   = 8'd125;
	localparam logic [7:0] CH_LPAREN   = 8'd40;
	localparam logic [7:0] CH_RPAREN   = 8'd41;
	localparam logic [7:0] CH_LBRACKET = 8'd91;
	localparam logic [7:0] CH_RBRACKET = 8'd93;
	localparam logic [7:0] CH_SQUOTE   = 8'd39;
	localparam logic [7:0] CH_DQUOTE   = 8'd34;
	localparam logic [7:0] CH_BSLASH   = 8'd92;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic       clear;
		logic [1:0] kind;
	} stk_cmd_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [1:0]         top;
	} stk_stat_t;

	typedef struct packed {
		logic       echo_valid;
		logic [7:0] echo_byte;
		logic [2:0] status;
	} bbc_res_t;

endpackage

>>> sv/bbc_stack.sv
// Kind stack: top entry in a register, one below it prefetched, the rest in memory.
module bbc_stack
	import bbc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  stk_cmd_t  cmd,
	output stk_stat_t stat
);

	logic [1:0]         mem [STACK_DEPTH];
	logic [DEPTH_W-1:0] depth_q;
	logic [1:0]         top_q;
	logic [1:0]         below_q;
	logic [DEPTH_W-1:0] wr_idx;
	logic [DEPTH_W-1:0] rd_idx;

	// Entry depth-1 lives in top_q, entry depth-2 in below_q; memory holds
	// every entry below the top at its own index.
	assign wr_idx = depth_q - DEPTH_W'(1);
	assign rd_idx = depth_q - DEPTH_W'(3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (en) begin
			if (cmd.clear) begin
				depth_q <= '0;
			end else if (cmd.push) begin
				depth_q <= depth_q + DEPTH_W'(1);
			end else if (cmd.pop) begin
				depth_q <= depth_q - DEPTH_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && !cmd.clear) begin
			if (cmd.push) begin
				if (depth_q != '0) begin
					mem[wr_idx[ADDR_W-1:0]] <= top_q;
				end
				top_q   <= cmd.kind;
				below_q <= top_q;
			end else if (cmd.pop) begin
				top_q   <= below_q;
				below_q <= mem[rd_idx[ADDR_W-1:0]];
			end
		end
	end

	assign stat.depth = depth_q;
	assign stat.top   = top_q;

endmodule

>>> sv/bbc_core.sv
// Lexer mode register and the per-word decision logic.
module bbc_core
	import bbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] data_byte,
	input  logic       end_of_stream,
	input  stk_stat_t  stat,
	output stk_cmd_t   cmd,
	output bbc_res_t   res
);

	localparam logic [2:0] MODE_CODE    = 3'd0;
	localparam logic [2:0] MODE_STR     = 3'd1;
	localparam logic [2:0] MODE_STR_ESC = 3'd2;
	localparam logic [2:0] MODE_CHR     = 3'd3;
	localparam logic [2:0] MODE_CHR_ESC = 3'd4;
	localparam logic [2:0] MODE_HALT    = 3'd5;

	logic [2:0] mode_q;
	logic [2:0] mode_d;
	logic [1:0] open_k;
	logic [1:0] close_k;

	always_comb begin
		open_k  = KIND_NONE;
		close_k = KIND_NONE;
		case (data_byte)
			CH_LBRACE:   open_k  = KIND_BRACE;
			CH_LPAREN:   open_k  = KIND_PAREN;
			CH_LBRACKET: open_k  = KIND_BRACKET;
			CH_RBRACE:   close_k = KIND_BRACE;
			CH_RPAREN:   close_k = KIND_PAREN;
			CH_RBRACKET: close_k = KIND_BRACKET;
			default: ;
		endcase
	end

	always_comb begin
		mode_d         = mode_q;
		cmd            = '0;
		cmd.kind       = open_k;
		res.echo_valid = 1'b0;
		res.echo_byte  = '0;
		res.status     = ST_RUN;
		if (end_of_stream) begin
			cmd.clear = 1'b1;
			mode_d    = MODE_CODE;
			case (mode_q)
				MODE_HALT: res.status = ST_RUN;
				MODE_CODE: res.status = (stat.depth != '0) ? ST_UNBAL : ST_BAL;
				default:   res.status = ST_BAL;
			endcase
		end else begin
			case (mode_q)
				MODE_CODE: begin
					if (open_k != KIND_NONE) begin
						res.echo_valid = 1'b1;
						res.echo_byte  = data_byte;
						if (stat.depth >= DEPTH_W'(STACK_DEPTH)) begin
							res.status = ST_OVF;
							mode_d     = MODE_HALT;
						end else begin
							cmd.push = 1'b1;
						end
					end else if (close_k != KIND_NONE) begin
						if (stat.depth != '0 && stat.top == close_k) begin
							cmd.pop        = 1'b1;
							res.echo_valid = 1'b1;
							res.echo_byte  = data_byte;
						end else begin
							// A mismatch reports the closer's own kind code.
							res.status = {1'b0, close_k};
							mode_d     = MODE_HALT;
						end
					end else begin
						res.echo_valid = 1'b1;
						res.echo_byte  = data_byte;
						if (data_byte == CH_DQUOTE) begin
							mode_d = MODE_STR;
						end else if (data_byte == CH_SQUOTE) begin
							mode_d = MODE_CHR;
						end
					end
				end
				MODE_STR: begin
					res.echo_valid = 1'b1;
					res.echo_byte  = data_byte;
					if (data_byte == CH_BSLASH) begin
						mode_d = MODE_STR_ESC;
					end else if (data_byte == CH_DQUOTE) begin
						mode_d = MODE_CODE;
					end
				end
				MODE_STR_ESC: begin
					res.echo_valid = 1'b1;
					res.echo_byte  = data_byte;
					mode_d         = MODE_STR;
				end
				MODE_CHR: begin
					res.echo_valid = 1'b1;
					res.echo_byte  = data_byte;
					if (data_byte == CH_BSLASH) begin
						mode_d = MODE_CHR_ESC;
					end else if (data_byte == CH_SQUOTE) begin
						mode_d = MODE_CODE;
					end
				end
				MODE_CHR_ESC: begin
					res.echo_valid = 1'b1;
					res.echo_byte  = data_byte;
					mode_d         = MODE_CHR;
				end
				default: begin
					mode_d = MODE_HALT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CODE;
		end else if (en) begin
			mode_q <= mode_d;
		end
	end

endmodule

>>> sv/bracket_balance_checker.sv
// Top level of the bracket balance checker: input register, core, stack, result register.
//
// The slave stream carries one source byte per word in s_axis_tdata; a word with
// s_axis_tlast high marks the end of the text and its data byte is ignored.
// Every accepted word produces exactly one result word on the master stream:
// m_axis_tdata holds the echoed byte (zero when nothing is echoed) and
// m_axis_tuser holds the echo-valid flag and the status code.
// Braces, parentheses and square brackets are checked for proper nesting,
// skipping anything inside double-quoted strings and single-quoted literals,
// where a backslash makes the next byte ordinary. A mismatched closer is not
// echoed, reports its kind and halts the checker until the next end word.
// An end word restarts the checker and reports balanced, unbalanced or, after a halt, run.
// Path: an accepted word is registered in the input stage, decided by the
// core, and its result is registered in the result register when the input
// stage advances.
// Throughput: one word per cycle when not stalled; the stack keeps its top and
// next entries in registers, so a push or pop needs only one memory access per cycle.
// When the receiver stalls, the result register holds and the input stage
// fills; s_axis_tready falls only when both are full.
// Reset clears the lexer mode, the stack depth and both valid flags; the stack
// memory needs no clearing since only entries below the depth are read.
module bracket_balance_checker
	import bbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  logic       s_axis_tlast,  // end_of_stream
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] echo_byte
	output logic [3:0] m_axis_tuser   // [0] echo_valid, [3:1] status
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       out_valid_q;
	bbc_res_t   out_q;
	logic       advance;
	stk_cmd_t   cmd;
	stk_stat_t  stat;
	bbc_res_t   res;

	// The input stage moves into the result register whenever that register is
	// empty or being drained this cycle; the checker state updates on the move.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
		end
	end

	bbc_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (advance),
		.data_byte     (byte_s1),
		.end_of_stream (end_s1),
		.stat          (stat),
		.cmd           (cmd),
		.res           (res)
	);

	bbc_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cmd    (cmd),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.echo_byte;
	assign m_axis_tuser  = {out_q.status, out_q.echo_valid};

endmodule
